/* design/sfcs_pkg.sv */
// Package for the SPI NOR flash command sequencer.
// Holds the sizes, command and operation codes, flash opcodes, phase type,
// item and result structs, and small decode functions. It depends on nothing.
package sfcs_pkg;

    localparam int PAGE_BYTES = 256;
    localparam int PAGE_AW    = $clog2(PAGE_BYTES);
    localparam int CNT_W      = $clog2(PAGE_BYTES + 1);
    localparam int FBI_W      = $clog2(PAGE_BYTES + 5);
    localparam int ADDR_W     = 24;
    localparam int COUNT_W    = 24;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [3:0] OP_RDSR1   = 4'd0;
    localparam logic [3:0] OP_RDSR2   = 4'd1;
    localparam logic [3:0] OP_RDSR3   = 4'd2;
    localparam logic [3:0] OP_WREN    = 4'd3;
    localparam logic [3:0] OP_WRDI    = 4'd4;
    localparam logic [3:0] OP_RDID    = 4'd5;
    localparam logic [3:0] OP_SE      = 4'd6;
    localparam logic [3:0] OP_BE      = 4'd7;
    localparam logic [3:0] OP_CE      = 4'd8;
    localparam logic [3:0] OP_PROGRAM = 4'd9;
    localparam logic [3:0] OP_READ    = 4'd10;

    localparam logic [7:0] FL_RDSR1 = 8'h05;
    localparam logic [7:0] FL_RDSR2 = 8'h35;
    localparam logic [7:0] FL_RDSR3 = 8'h15;
    localparam logic [7:0] FL_WREN  = 8'h06;
    localparam logic [7:0] FL_WRDI  = 8'h04;
    localparam logic [7:0] FL_RDID  = 8'h9F;
    localparam logic [7:0] FL_SE    = 8'h20;
    localparam logic [7:0] FL_BE    = 8'hD8;
    localparam logic [7:0] FL_CE    = 8'hC7;
    localparam logic [7:0] FL_PP    = 8'h02;
    localparam logic [7:0] FL_READ  = 8'h03;
    localparam logic [7:0] FL_DUMMY = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WREN,
        PH_GAP_MAIN,
        PH_MAIN,
        PH_GAP_POLL,
        PH_POLL
    } t_phase;

    typedef struct packed {
        t_cmd                 cmd;
        logic [3:0]           op;
        logic [ADDR_W-1:0]    flash_address;
        logic [COUNT_W-1:0]   byte_count;
        logic [7:0]           load_data;
        logic                 miso_bit;
    } t_item;

    typedef struct packed {
        logic       chip_select_n;
        logic       clock_pulse;
        logic       mosi_bit;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       op_done;
        logic       idle;
        logic       rejected;
    } t_result;

    function automatic logic [7:0] opcode_of(logic [3:0] op);
        logic [7:0] code;
        unique case (op)
            OP_RDSR1:   code = FL_RDSR1;
            OP_RDSR2:   code = FL_RDSR2;
            OP_RDSR3:   code = FL_RDSR3;
            OP_WREN:    code = FL_WREN;
            OP_WRDI:    code = FL_WRDI;
            OP_RDID:    code = FL_RDID;
            OP_SE:      code = FL_SE;
            OP_BE:      code = FL_BE;
            OP_CE:      code = FL_CE;
            OP_PROGRAM: code = FL_PP;
            OP_READ:    code = FL_READ;
            default:    code = FL_DUMMY;
        endcase
        return code;
    endfunction

    function automatic logic [FBI_W-1:0] header_len(logic [3:0] op);
        logic [FBI_W-1:0] len;
        if (op == OP_SE || op == OP_BE || op == OP_PROGRAM || op == OP_READ) begin
            len = FBI_W'(4);
        end else begin
            len = FBI_W'(1);
        end
        return len;
    endfunction

    function automatic logic returns_bytes(logic [3:0] op);
        return (op <= OP_RDSR3) || (op == OP_RDID) || (op == OP_READ);
    endfunction

    function automatic logic polls_busy(logic [3:0] op);
        return (op >= OP_SE) && (op <= OP_PROGRAM);
    endfunction

endpackage

/* design/sfcs_core.sv */
// Frame sequencer and page buffer of the SPI NOR flash command sequencer.
// Takes one accepted word at a time and forms its result word.
// Depends on sfcs_pkg.
module sfcs_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  sfcs_pkg::t_item  i_item,
    output sfcs_pkg::t_result o_result
);

    logic [7:0]                   r_page_mem [sfcs_pkg::PAGE_BYTES];
    logic [7:0]                   r_rd_data;
    logic                         wr_en;
    logic [sfcs_pkg::PAGE_AW-1:0] wr_addr;
    logic [sfcs_pkg::PAGE_AW-1:0] rd_addr;
    logic [sfcs_pkg::FBI_W-1:0]   rd_index;

    sfcs_pkg::t_phase             r_phase, n_phase;
    logic [sfcs_pkg::CNT_W-1:0]   r_loaded, n_loaded;
    logic [3:0]                   r_cur_op, n_cur_op;
    logic [sfcs_pkg::ADDR_W-1:0]  r_address, n_address;
    logic [sfcs_pkg::COUNT_W-1:0] r_bytes_left, n_bytes_left;
    logic [7:0]                   r_shift_out, n_shift_out;
    logic [7:0]                   r_shift_in, n_shift_in;
    logic [2:0]                   r_bit_pos, n_bit_pos;
    logic [sfcs_pkg::FBI_W-1:0]   r_fbi, n_fbi;

    logic                         in_frame;
    logic [sfcs_pkg::FBI_W-1:0]   hdr;
    logic [7:0]                   next_tx;

    assign in_frame = (r_phase == sfcs_pkg::PH_WREN) || (r_phase == sfcs_pkg::PH_MAIN) ||
                      (r_phase == sfcs_pkg::PH_POLL);
    assign hdr      = sfcs_pkg::header_len(r_cur_op);

    // The read address follows the next byte index, so page data is ready on the next tick.
    assign rd_index = n_fbi - sfcs_pkg::FBI_W'(4);
    assign rd_addr  = rd_index[sfcs_pkg::PAGE_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_page_mem[wr_addr] <= i_item.load_data;
        end
        r_rd_data <= r_page_mem[rd_addr];
    end

    always_comb begin
        next_tx = sfcs_pkg::FL_DUMMY;
        unique case (r_phase)
            sfcs_pkg::PH_WREN: begin
                next_tx = sfcs_pkg::FL_WREN;
            end
            sfcs_pkg::PH_POLL: begin
                next_tx = (r_fbi == '0) ? sfcs_pkg::FL_RDSR1 : sfcs_pkg::FL_DUMMY;
            end
            default: begin
                if (r_fbi < hdr) begin
                    unique case (r_fbi)
                        sfcs_pkg::FBI_W'(0): next_tx = sfcs_pkg::opcode_of(r_cur_op);
                        sfcs_pkg::FBI_W'(1): next_tx = r_address[23:16];
                        sfcs_pkg::FBI_W'(2): next_tx = r_address[15:8];
                        default:             next_tx = r_address[7:0];
                    endcase
                end else if (r_cur_op == sfcs_pkg::OP_PROGRAM) begin
                    next_tx = r_rd_data;
                end
            end
        endcase
    end

    always_comb begin
        logic [7:0]                   tx;
        logic [7:0]                   sin_nx;
        logic [sfcs_pkg::FBI_W-1:0]   fbi_nx;
        logic [sfcs_pkg::COUNT_W-1:0] bl_nx;
        logic                         end_op;

        n_phase      = r_phase;
        n_loaded     = r_loaded;
        n_cur_op     = r_cur_op;
        n_address    = r_address;
        n_bytes_left = r_bytes_left;
        n_shift_out  = r_shift_out;
        n_shift_in   = r_shift_in;
        n_bit_pos    = r_bit_pos;
        n_fbi        = r_fbi;
        wr_en        = 1'b0;
        wr_addr      = r_loaded[sfcs_pkg::PAGE_AW-1:0];
        tx           = r_shift_out;
        sin_nx       = {r_shift_in[6:0], i_item.miso_bit};
        fbi_nx       = r_fbi;
        bl_nx        = r_bytes_left;
        end_op       = 1'b0;
        o_result               = '0;
        o_result.chip_select_n = !in_frame;

        if (i_take) begin
            unique case (i_item.cmd)
                sfcs_pkg::CMD_LOAD: begin
                    if (r_phase == sfcs_pkg::PH_IDLE &&
                        r_loaded < sfcs_pkg::CNT_W'(sfcs_pkg::PAGE_BYTES)) begin
                        wr_en    = 1'b1;
                        n_loaded = r_loaded + sfcs_pkg::CNT_W'(1);
                    end
                end
                sfcs_pkg::CMD_START: begin
                    if (r_phase != sfcs_pkg::PH_IDLE || i_item.op > sfcs_pkg::OP_READ ||
                        (i_item.op == sfcs_pkg::OP_PROGRAM &&
                         (i_item.byte_count == '0 ||
                          i_item.byte_count > sfcs_pkg::COUNT_W'(sfcs_pkg::PAGE_BYTES)))) begin
                        o_result.rejected = 1'b1;
                    end else begin
                        n_cur_op  = i_item.op;
                        n_address = i_item.flash_address;
                        if (i_item.op <= sfcs_pkg::OP_RDSR3) begin
                            n_bytes_left = sfcs_pkg::COUNT_W'(1);
                        end else if (i_item.op == sfcs_pkg::OP_RDID) begin
                            n_bytes_left = sfcs_pkg::COUNT_W'(3);
                        end else if (i_item.op == sfcs_pkg::OP_PROGRAM ||
                                     i_item.op == sfcs_pkg::OP_READ) begin
                            n_bytes_left = i_item.byte_count;
                        end else begin
                            n_bytes_left = '0;
                        end
                        if (i_item.op == sfcs_pkg::OP_PROGRAM) begin
                            n_loaded = '0;
                        end
                        n_fbi     = '0;
                        n_bit_pos = '0;
                        n_phase   = sfcs_pkg::polls_busy(i_item.op) ? sfcs_pkg::PH_WREN
                                                                    : sfcs_pkg::PH_MAIN;
                    end
                end
                sfcs_pkg::CMD_TICK: begin
                    if (r_phase == sfcs_pkg::PH_GAP_MAIN || r_phase == sfcs_pkg::PH_GAP_POLL) begin
                        n_phase   = (r_phase == sfcs_pkg::PH_GAP_MAIN) ? sfcs_pkg::PH_MAIN
                                                                       : sfcs_pkg::PH_POLL;
                        n_fbi     = '0;
                        n_bit_pos = '0;
                    end else if (in_frame) begin
                        if (r_bit_pos == '0) begin
                            tx = next_tx;
                        end
                        o_result.mosi_bit    = tx[7];
                        o_result.clock_pulse = 1'b1;
                        n_shift_out          = {tx[6:0], 1'b0};
                        n_shift_in           = sin_nx;
                        n_bit_pos            = r_bit_pos + 3'd1;
                        if (r_bit_pos == 3'd7) begin
                            unique case (r_phase)
                                sfcs_pkg::PH_WREN: begin
                                    n_phase = sfcs_pkg::PH_GAP_MAIN;
                                end
                                sfcs_pkg::PH_POLL: begin
                                    fbi_nx = r_fbi + sfcs_pkg::FBI_W'(1);
                                    if (fbi_nx >= sfcs_pkg::FBI_W'(2)) begin
                                        if (sin_nx[0]) begin
                                            n_phase = sfcs_pkg::PH_GAP_POLL;
                                        end else begin
                                            end_op = 1'b1;
                                        end
                                    end
                                end
                                default: begin
                                    if (r_fbi < hdr) begin
                                        fbi_nx = r_fbi + sfcs_pkg::FBI_W'(1);
                                    end else if (r_bytes_left != '0) begin
                                        if (sfcs_pkg::returns_bytes(r_cur_op)) begin
                                            o_result.rx_valid = 1'b1;
                                            o_result.rx_byte  = sin_nx;
                                            o_result.rx_last  =
                                                (r_bytes_left == sfcs_pkg::COUNT_W'(1));
                                        end
                                        if (r_cur_op == sfcs_pkg::OP_PROGRAM) begin
                                            fbi_nx = r_fbi + sfcs_pkg::FBI_W'(1);
                                        end
                                        bl_nx = r_bytes_left - sfcs_pkg::COUNT_W'(1);
                                    end
                                    if (fbi_nx >= hdr && bl_nx == '0) begin
                                        if (sfcs_pkg::polls_busy(r_cur_op)) begin
                                            n_phase = sfcs_pkg::PH_GAP_POLL;
                                        end else begin
                                            end_op = 1'b1;
                                        end
                                    end
                                end
                            endcase
                            n_fbi        = fbi_nx;
                            n_bytes_left = bl_nx;
                            if (end_op) begin
                                o_result.op_done = 1'b1;
                                n_phase          = sfcs_pkg::PH_IDLE;
                                n_fbi            = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.idle = (n_phase == sfcs_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sfcs_pkg::PH_IDLE;
            r_loaded     <= '0;
            r_cur_op     <= '0;
            r_bytes_left <= '0;
            r_bit_pos    <= '0;
            r_fbi        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_loaded     <= n_loaded;
            r_cur_op     <= n_cur_op;
            r_bytes_left <= n_bytes_left;
            r_bit_pos    <= n_bit_pos;
            r_fbi        <= n_fbi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_address   <= n_address;
        r_shift_out <= n_shift_out;
        r_shift_in  <= n_shift_in;
    end

endmodule

/* design/spi_flash_command_sequencer.sv */
// Top level of the SPI NOR flash command sequencer: handshakes and output register.
// Depends on sfcs_pkg and sfcs_core.
//
//   Channel  Direction  Handshake                  Payload
//   in       to block   i_in_valid / o_in_stall    i_cmd i_op i_flash_address i_byte_count
//                                                  i_load_data i_miso_bit
//   out      from block o_out_valid / i_out_stall  o_chip_select_n ... o_rejected
//
// One word is accepted in every clock cycle while the output register is free or being
// emptied; its result word appears in the output register in the next cycle.
// Page data is fetched from the page buffer RAM into a read register ahead of its first bit.
// Reset is synchronous; the page buffer is not cleared and holds unknown data until loaded.
// A stall on the output while the output register is valid holds the result and stalls the input in the same cycle.
module spi_flash_command_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_cmd,
    input  logic [3:0]                     i_op,
    input  logic [sfcs_pkg::ADDR_W-1:0]    i_flash_address,
    input  logic [sfcs_pkg::COUNT_W-1:0]   i_byte_count,
    input  logic [7:0]                     i_load_data,
    input  logic                           i_miso_bit,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_chip_select_n,
    output logic                           o_clock_pulse,
    output logic                           o_mosi_bit,
    output logic                           o_rx_valid,
    output logic [7:0]                     o_rx_byte,
    output logic                           o_rx_last,
    output logic                           o_op_done,
    output logic                           o_idle,
    output logic                           o_rejected
);

    logic               take;
    sfcs_pkg::t_item    item;
    sfcs_pkg::t_result  result;
    sfcs_pkg::t_result  r_out;
    logic               r_out_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    assign item.cmd           = sfcs_pkg::t_cmd'(i_cmd);
    assign item.op            = i_op;
    assign item.flash_address = i_flash_address;
    assign item.byte_count    = i_byte_count;
    assign item.load_data     = i_load_data;
    assign item.miso_bit      = i_miso_bit;

    sfcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chip_select_n = r_out.chip_select_n;
    assign o_clock_pulse   = r_out.clock_pulse;
    assign o_mosi_bit      = r_out.mosi_bit;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_byte       = r_out.rx_byte;
    assign o_rx_last       = r_out.rx_last;
    assign o_op_done       = r_out.op_done;
    assign o_idle          = r_out.idle;
    assign o_rejected      = r_out.rejected;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the SPI NOR flash command sequencer.
// A directed table and constrained-by-hand random words drive the block; a bit-period
// predictor of the sequencer checks every result word. Depends on sfcs_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OP_BAD_LO = 4'd11;
    localparam logic [3:0] OP_BAD_HI = 4'd15;
    localparam int RANDOM_WORDS = 1300;
    localparam int BULK_AFTER = 400;

    typedef enum {LIT_NONE, LIT_IDLE, LIT_REJECT} t_lit;

    typedef struct {
        sfcs_pkg::t_cmd cmd;
        logic [3:0]     op;
        logic [23:0]    addr;
        logic [23:0]    count;
        logic [7:0]     data;
        logic           miso;
        bit             run;
        t_lit           lit;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = sfcs_pkg::CMD_NONE;
    logic [3:0]  i_op = sfcs_pkg::OP_RDSR1;
    logic [23:0] i_flash_address = '0;
    logic [23:0] i_byte_count = '0;
    logic [7:0]  i_load_data = '0;
    logic        i_miso_bit = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_chip_select_n;
    logic        o_clock_pulse;
    logic        o_mosi_bit;
    logic        o_rx_valid;
    logic [7:0]  o_rx_byte;
    logic        o_rx_last;
    logic        o_op_done;
    logic        o_idle;
    logic        o_rejected;

    spi_flash_command_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_op            (i_op),
        .i_flash_address (i_flash_address),
        .i_byte_count    (i_byte_count),
        .i_load_data     (i_load_data),
        .i_miso_bit      (i_miso_bit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chip_select_n (o_chip_select_n),
        .o_clock_pulse   (o_clock_pulse),
        .o_mosi_bit      (o_mosi_bit),
        .o_rx_valid      (o_rx_valid),
        .o_rx_byte       (o_rx_byte),
        .o_rx_last       (o_rx_last),
        .o_op_done       (o_op_done),
        .o_idle          (o_idle),
        .o_rejected      (o_rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted sequencer state.
    logic [7:0]       pg_mem [sfcs_pkg::PAGE_BYTES];
    logic [8:0]       pg_fill = '0;
    int unsigned      pg_written = 0;
    sfcs_pkg::t_phase seq_phase = sfcs_pkg::PH_IDLE;
    logic [3:0]       seq_op = sfcs_pkg::OP_RDSR1;
    logic [23:0]      seq_addr = '0;
    logic [23:0]      seq_left = '0;
    logic [7:0]       tx_sh = '0;
    logic [7:0]       rx_sh = '0;
    logic [2:0]       bit_cnt = '0;
    logic [8:0]       byte_idx = '0;

    sfcs_pkg::t_result pending_results [$];
    t_dir_row          dir_tab [$];
    int                dir_pos = 0;
    bit                dir_run = 1'b0;
    logic              dir_miso = 1'b0;
    int                rand_count = 0;
    int                load_left = 0;
    bit                bulk_on = 1'b0;
    bit                bulk_pending = 1'b0;
    bit                bulk_done = 1'b0;
    bit                stim_done = 1'b0;
    int                fail_cnt = 0;

    sfcs_pkg::t_item   cur_word;
    t_lit              cur_lit = LIT_NONE;
    int                burst_left = 0;
    int                gap_left = 0;

    function automatic logic [7:0] flash_opcode(logic [3:0] op);
        case (op)
            sfcs_pkg::OP_RDSR1:   return sfcs_pkg::FL_RDSR1;
            sfcs_pkg::OP_RDSR2:   return sfcs_pkg::FL_RDSR2;
            sfcs_pkg::OP_RDSR3:   return sfcs_pkg::FL_RDSR3;
            sfcs_pkg::OP_WREN:    return sfcs_pkg::FL_WREN;
            sfcs_pkg::OP_WRDI:    return sfcs_pkg::FL_WRDI;
            sfcs_pkg::OP_RDID:    return sfcs_pkg::FL_RDID;
            sfcs_pkg::OP_SE:      return sfcs_pkg::FL_SE;
            sfcs_pkg::OP_BE:      return sfcs_pkg::FL_BE;
            sfcs_pkg::OP_CE:      return sfcs_pkg::FL_CE;
            sfcs_pkg::OP_PROGRAM: return sfcs_pkg::FL_PP;
            sfcs_pkg::OP_READ:    return sfcs_pkg::FL_READ;
            default:              return sfcs_pkg::FL_DUMMY;
        endcase
    endfunction

    function automatic int unsigned addr_frame_len(logic [3:0] op);
        if (op == sfcs_pkg::OP_SE || op == sfcs_pkg::OP_BE || op == sfcs_pkg::OP_PROGRAM ||
            op == sfcs_pkg::OP_READ) begin
            return 4;
        end
        return 1;
    endfunction

    function automatic bit to_host(logic [3:0] op);
        return (op <= sfcs_pkg::OP_RDSR3) || (op == sfcs_pkg::OP_RDID) ||
               (op == sfcs_pkg::OP_READ);
    endfunction

    function automatic bit needs_wren(logic [3:0] op);
        return (op >= sfcs_pkg::OP_SE) && (op <= sfcs_pkg::OP_PROGRAM);
    endfunction

    function automatic logic [7:0] tx_byte();
        int unsigned h;
        logic [8:0] idx;
        h = addr_frame_len(seq_op);
        idx = byte_idx - 9'(h);
        if (seq_phase == sfcs_pkg::PH_WREN) begin
            return sfcs_pkg::FL_WREN;
        end
        if (seq_phase == sfcs_pkg::PH_POLL) begin
            return (byte_idx == 0) ? sfcs_pkg::FL_RDSR1 : sfcs_pkg::FL_DUMMY;
        end
        if (byte_idx < h) begin
            case (byte_idx)
                9'd0:    return flash_opcode(seq_op);
                9'd1:    return seq_addr[23:16];
                9'd2:    return seq_addr[15:8];
                default: return seq_addr[7:0];
            endcase
        end
        if (seq_op == sfcs_pkg::OP_PROGRAM) begin
            return pg_mem[idx[7:0]];
        end
        return sfcs_pkg::FL_DUMMY;
    endfunction

    function automatic sfcs_pkg::t_result sequencer_step(sfcs_pkg::t_item w);
        sfcs_pkg::t_result r;
        logic framed;
        logic finish;
        int unsigned h;
        r = '0;
        finish = 1'b0;
        framed = (seq_phase == sfcs_pkg::PH_WREN) || (seq_phase == sfcs_pkg::PH_MAIN) ||
                 (seq_phase == sfcs_pkg::PH_POLL);
        r.chip_select_n = !framed;
        case (w.cmd)
            sfcs_pkg::CMD_LOAD: begin
                if (seq_phase == sfcs_pkg::PH_IDLE && pg_fill < sfcs_pkg::PAGE_BYTES) begin
                    pg_mem[pg_fill[7:0]] = w.load_data;
                    pg_fill = pg_fill + 9'd1;
                    if (pg_fill > pg_written) pg_written = pg_fill;
                end
            end
            sfcs_pkg::CMD_START: begin
                if (seq_phase != sfcs_pkg::PH_IDLE || w.op > sfcs_pkg::OP_READ ||
                    (w.op == sfcs_pkg::OP_PROGRAM &&
                     (w.byte_count == 0 || w.byte_count > sfcs_pkg::PAGE_BYTES))) begin
                    r.rejected = 1'b1;
                end else begin
                    seq_op = w.op;
                    seq_addr = w.flash_address;
                    if (w.op <= sfcs_pkg::OP_RDSR3) seq_left = 24'd1;
                    else if (w.op == sfcs_pkg::OP_RDID) seq_left = 24'd3;
                    else if (w.op == sfcs_pkg::OP_PROGRAM || w.op == sfcs_pkg::OP_READ)
                        seq_left = w.byte_count;
                    else seq_left = '0;
                    if (w.op == sfcs_pkg::OP_PROGRAM) pg_fill = '0;
                    byte_idx = '0;
                    bit_cnt = '0;
                    seq_phase = needs_wren(w.op) ? sfcs_pkg::PH_WREN : sfcs_pkg::PH_MAIN;
                end
            end
            sfcs_pkg::CMD_TICK: begin
                if (seq_phase == sfcs_pkg::PH_GAP_MAIN || seq_phase == sfcs_pkg::PH_GAP_POLL) begin
                    seq_phase = (seq_phase == sfcs_pkg::PH_GAP_MAIN) ? sfcs_pkg::PH_MAIN
                                                                     : sfcs_pkg::PH_POLL;
                    byte_idx = '0;
                    bit_cnt = '0;
                end else if (framed) begin
                    if (bit_cnt == 0) tx_sh = tx_byte();
                    r.mosi_bit = tx_sh[7];
                    tx_sh = tx_sh << 1;
                    rx_sh = {rx_sh[6:0], w.miso_bit};
                    bit_cnt = bit_cnt + 3'd1;
                    r.clock_pulse = 1'b1;
                    if (bit_cnt == 0) begin
                        if (seq_phase == sfcs_pkg::PH_WREN) begin
                            seq_phase = sfcs_pkg::PH_GAP_MAIN;
                        end else if (seq_phase == sfcs_pkg::PH_POLL) begin
                            byte_idx = byte_idx + 9'd1;
                            if (byte_idx >= 2) begin
                                if (rx_sh[0]) seq_phase = sfcs_pkg::PH_GAP_POLL;
                                else finish = 1'b1;
                            end
                        end else begin
                            h = addr_frame_len(seq_op);
                            if (byte_idx < h) begin
                                byte_idx = byte_idx + 9'd1;
                            end else if (seq_left > 0) begin
                                if (to_host(seq_op)) begin
                                    r.rx_valid = 1'b1;
                                    r.rx_byte = rx_sh;
                                    r.rx_last = (seq_left == 1);
                                end
                                if (seq_op == sfcs_pkg::OP_PROGRAM) byte_idx = byte_idx + 9'd1;
                                seq_left = seq_left - 24'd1;
                            end
                            if (byte_idx >= h && seq_left == 0) begin
                                if (needs_wren(seq_op)) seq_phase = sfcs_pkg::PH_GAP_POLL;
                                else finish = 1'b1;
                            end
                        end
                        if (finish) begin
                            r.op_done = 1'b1;
                            seq_phase = sfcs_pkg::PH_IDLE;
                            byte_idx = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.idle = (seq_phase == sfcs_pkg::PH_IDLE);
        return r;
    endfunction

    function automatic sfcs_pkg::t_result idle_word(logic rej);
        sfcs_pkg::t_result r;
        r = '0;
        r.chip_select_n = 1'b1;
        r.idle = 1'b1;
        r.rejected = rej;
        return r;
    endfunction

    function automatic void add_row(sfcs_pkg::t_cmd c, logic [3:0] op, logic [23:0] a,
                                    logic [23:0] n, logic [7:0] d, logic m, bit run,
                                    t_lit lit);
        t_dir_row row;
        row.cmd = c;
        row.op = op;
        row.addr = a;
        row.count = n;
        row.data = d;
        row.miso = m;
        row.run = run;
        row.lit = lit;
        dir_tab.push_back(row);
    endfunction

    function automatic sfcs_pkg::t_item tick_word(logic m);
        sfcs_pkg::t_item w;
        w.cmd = sfcs_pkg::CMD_TICK;
        w.op = 4'($urandom);
        w.flash_address = 24'($urandom);
        w.byte_count = 24'($urandom);
        w.load_data = 8'($urandom);
        w.miso_bit = m;
        return w;
    endfunction

    function automatic sfcs_pkg::t_item random_word();
        sfcs_pkg::t_item w;
        int pick;
        int cap;
        bit counted;
        w = tick_word(1'($urandom));
        counted = 1'b1;
        if (seq_phase != sfcs_pkg::PH_IDLE) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) w.cmd = sfcs_pkg::CMD_LOAD;
            else if (pick < 7) w.cmd = sfcs_pkg::CMD_START;
            else if (pick < 9) w.cmd = sfcs_pkg::CMD_NONE;
            counted = (pick >= 9);
        end else begin
            if (load_left == 0 && !bulk_pending) bulk_on = 1'b0;
            if (!bulk_done && rand_count >= BULK_AFTER && load_left == 0) begin
                bulk_done = 1'b1;
                bulk_on = 1'b1;
                bulk_pending = 1'b1;
                load_left = sfcs_pkg::PAGE_BYTES;
            end
            pick = $urandom_range(0, 99);
            if (load_left == 0 && !bulk_pending && pick >= 30 && pg_written == 0 &&
                $urandom_range(sfcs_pkg::OP_RDSR1, sfcs_pkg::OP_READ) == sfcs_pkg::OP_PROGRAM) begin
                load_left = $urandom_range(1, 8);
            end
            if (load_left > 0) begin
                w.cmd = sfcs_pkg::CMD_LOAD;
                load_left--;
            end else if (bulk_pending) begin
                w.cmd = sfcs_pkg::CMD_START;
                w.op = sfcs_pkg::OP_PROGRAM;
                w.byte_count = 24'(sfcs_pkg::PAGE_BYTES);
                bulk_pending = 1'b0;
            end else if (pick < 6) begin
                w.cmd = ($urandom_range(0, 1) == 0) ? sfcs_pkg::CMD_NONE : sfcs_pkg::CMD_TICK;
                counted = 1'b0;
            end else if (pick < 10) begin
                w.cmd = sfcs_pkg::CMD_START;
                counted = 1'b0;
                if ($urandom_range(0, 1) == 0) begin
                    w.op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
                end else begin
                    w.op = sfcs_pkg::OP_PROGRAM;
                    case ($urandom_range(0, 2))
                        0:       w.byte_count = '0;
                        1:       w.byte_count = 24'(sfcs_pkg::PAGE_BYTES + 1);
                        default: w.byte_count =
                                     24'($urandom_range(sfcs_pkg::PAGE_BYTES + 1, 24'hFFFFFF));
                    endcase
                end
            end else if (pick < 30) begin
                w.cmd = sfcs_pkg::CMD_LOAD;
                load_left = $urandom_range(0, 7);
            end else begin
                w.cmd = sfcs_pkg::CMD_START;
                w.op = 4'($urandom_range(sfcs_pkg::OP_RDSR1, sfcs_pkg::OP_READ));
                if (w.op == sfcs_pkg::OP_PROGRAM && pg_written == 0) w.op = sfcs_pkg::OP_READ;
                if (w.op == sfcs_pkg::OP_PROGRAM) begin
                    cap = (pg_written < 8) ? pg_written : 8;
                    if ($urandom_range(0, 9) == 0) cap = pg_written;
                    w.byte_count = 24'($urandom_range(1, cap));
                end else if (w.op == sfcs_pkg::OP_READ) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 4) w.byte_count = '0;
                    else if (pick < 18) w.byte_count = 24'($urandom_range(1, 4));
                    else w.byte_count = 24'($urandom_range(5, 32));
                end
            end
        end
        if (counted && !bulk_on) rand_count++;
        return w;
    endfunction

    function automatic void next_word(output sfcs_pkg::t_item w, output t_lit lk,
                                      output bit got);
        t_dir_row row;
        got = 1'b1;
        lk = LIT_NONE;
        w = tick_word(dir_miso);
        if (dir_run && seq_phase != sfcs_pkg::PH_IDLE) begin
            return;
        end
        dir_run = 1'b0;
        if (dir_pos < dir_tab.size()) begin
            row = dir_tab[dir_pos];
            dir_pos++;
            w.cmd = row.cmd;
            w.op = row.op;
            w.flash_address = row.addr;
            w.byte_count = row.count;
            w.load_data = row.data;
            w.miso_bit = row.miso;
            dir_run = row.run;
            dir_miso = row.miso;
            lk = row.lit;
        end else if (rand_count >= RANDOM_WORDS && seq_phase == sfcs_pkg::PH_IDLE &&
                     load_left == 0 && !bulk_pending) begin
            got = 1'b0;
        end else begin
            w = random_word();
        end
    endfunction

    function automatic string show(sfcs_pkg::t_result r);
        return $sformatf("cs_n=%b sck=%b mosi=%b rxv=%b rxb=%h rxl=%b done=%b idle=%b rej=%b",
                         r.chip_select_n, r.clock_pulse, r.mosi_bit, r.rx_valid, r.rx_byte,
                         r.rx_last, r.op_done, r.idle, r.rejected);
    endfunction

    initial begin
        add_row(sfcs_pkg::CMD_TICK, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h00, 1'b1, 0,
                LIT_IDLE);
        add_row(sfcs_pkg::CMD_NONE, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h00, 1'b0, 0,
                LIT_IDLE);
        add_row(sfcs_pkg::CMD_START, OP_BAD_HI, 24'hFFFFFF, 24'h1, 8'h00, 1'b0, 0,
                LIT_REJECT);
        add_row(sfcs_pkg::CMD_START, OP_BAD_LO, 24'h0, 24'h1, 8'h00, 1'b0, 0, LIT_REJECT);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_PROGRAM, 24'h0, 24'h0, 8'h00, 1'b0, 0,
                LIT_REJECT);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_PROGRAM, 24'h0,
                24'(sfcs_pkg::PAGE_BYTES + 1), 8'h00, 1'b0, 0, LIT_REJECT);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_PROGRAM, 24'hFFFFFF, 24'hFFFFFF, 8'h00,
                1'b0, 0, LIT_REJECT);
        add_row(sfcs_pkg::CMD_LOAD, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'hFF, 1'b0, 0,
                LIT_IDLE);
        add_row(sfcs_pkg::CMD_LOAD, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h00, 1'b0, 0,
                LIT_IDLE);
        add_row(sfcs_pkg::CMD_LOAD, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'hA5, 1'b0, 0,
                LIT_IDLE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_PROGRAM, 24'hFFFFFF, 24'h3, 8'h00, 1'b0, 0,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_LOAD, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h5A, 1'b1, 0,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_RDSR1, 24'h0, 24'h1, 8'h00, 1'b1, 0,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_NONE, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h00, 1'b1, 0,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_TICK, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_RDSR1, 24'h0, 24'h0, 8'h00, 1'b1, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_RDSR2, 24'h0, 24'h0, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_RDSR3, 24'hFFFFFF, 24'hFFFFFF, 8'h00,
                1'b1, 1, LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_WREN, 24'h0, 24'h0, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_WRDI, 24'h0, 24'h0, 8'h00, 1'b1, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_RDID, 24'hFFFFFF, 24'hFFFFFF, 8'h00,
                1'b1, 1, LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_SE, 24'h0, 24'h0, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_BE, 24'hFFFFFF, 24'h0, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_CE, 24'h0, 24'h0, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_READ, 24'hFFFFFF, 24'h0, 8'h00, 1'b1, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_READ, 24'h0, 24'h2, 8'h00, 1'b0, 1,
                LIT_NONE);
        add_row(sfcs_pkg::CMD_START, sfcs_pkg::OP_PROGRAM, 24'h0, 24'h1, 8'h00, 1'b0, 1,
                LIT_NONE);
    end

    always @(posedge i_clk) begin : sender
        sfcs_pkg::t_item nxt;
        t_lit lk;
        bit got;
        logic v;
        sfcs_pkg::t_result res;
        v = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                res = sequencer_step(cur_word);
                if (cur_lit == LIT_IDLE) res = idle_word(1'b0);
                else if (cur_lit == LIT_REJECT) res = idle_word(1'b1);
                pending_results.push_back(res);
                v = 1'b0;
            end
            if (!v && !stim_done) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    next_word(nxt, lk, got);
                    if (got) begin
                        cur_word = nxt;
                        cur_lit = lk;
                        v = 1'b1;
                        i_cmd <= nxt.cmd;
                        i_op <= nxt.op;
                        i_flash_address <= nxt.flash_address;
                        i_byte_count <= nxt.byte_count;
                        i_load_data <= nxt.load_data;
                        i_miso_bit <= nxt.miso_bit;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(1, 40);
                            case ($urandom_range(0, 9))
                                0, 1, 2, 3: gap_left = 0;
                                9:          gap_left = $urandom_range(10, 30);
                                default:    gap_left = $urandom_range(1, 5);
                            endcase
                        end
                    end else begin
                        stim_done = 1'b1;
                    end
                end
            end
        end
        i_in_valid <= v;
    end

    int rx_cycles = 0;
    int hold_left = 0;
    int seg_left = 0;
    int stall_pct = 0;

    always @(posedge i_clk) begin : receiver
        logic s;
        s = 1'b0;
        if (i_rst_n) begin
            rx_cycles++;
            if (rx_cycles == 2500) hold_left = 300;
            if (hold_left > 0) begin
                hold_left--;
                s = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 15;
                        3:       stall_pct = 40;
                        default: stall_pct = 75;
                    endcase
                end
                seg_left--;
                s = ($urandom_range(0, 99) < stall_pct);
            end
        end
        i_out_stall <= s;
    end

    always @(posedge i_clk) begin : monitor
        sfcs_pkg::t_result got;
        sfcs_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.chip_select_n = o_chip_select_n;
            got.clock_pulse = o_clock_pulse;
            got.mosi_bit = o_mosi_bit;
            got.rx_valid = o_rx_valid;
            got.rx_byte = o_rx_byte;
            got.rx_last = o_rx_last;
            got.op_done = o_op_done;
            got.idle = o_idle;
            got.rejected = o_rejected;
            if (pending_results.size() == 0) begin
                if (fail_cnt < 10) $display("unexpected result word: %s", show(got));
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    if (fail_cnt < 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : main
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        n = 0;
        while (pending_results.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("result words never delivered: %0d", pending_results.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
